@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

@@ rtl/salc_pkg.sv @@
`timescale 1ns / 1ps

package salc_pkg;

  // Request kinds carried in req_type
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_IFETCH = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
  } salc_in_t;

  typedef struct packed {
    logic        hit;
    logic        miss;
    logic        eviction;
    logic        second_hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } salc_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch request, start set read
    logic commit;   // update counters, load result register
    logic write;    // write the updated set back
  } salc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fetch;    // held request is an instruction fetch
  } salc_sts_t;

endpackage

@@ rtl/salc_ram.sv @@
`timescale 1ns / 1ps

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/salc_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module salc_ctrl import salc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  salc_sts_t sts_i,
  output salc_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold the looked-up set until the result register can take the beat
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          cmd_o.write  = !sts_i.fetch;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_NEXT(a_capture_blocks, clk_i, rst_ni, cmd_o.capture, !in_ready_o)
  `ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, cmd_o.commit, out_valid_o && in_ready_o)
  `ASSERT_IMPL(a_write_on_commit, clk_i, rst_ni, cmd_o.write, cmd_o.commit)

endmodule

@@ rtl/salc_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module salc_dp import salc_pkg::*; #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  salc_in_t              in_i,
  input  salc_cmd_t             cmd_i,
  output salc_sts_t             sts_o,
  output salc_out_t             out_o
);

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W   = WAY_W;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int ENT_W   = 1 + AGE_W + ADDR_WIDTH;
  localparam int ROW_W   = MAX_WAYS * ENT_W;

  localparam logic [3:0]       SET_LIM_L = 4'(SET_LIM);
  localparam logic [AGE_W-1:0] AGE_MAX   = AGE_W'(MAX_WAYS - 1);

  function automatic logic [31:0] sat_add(logic [31:0] v, logic [1:0] inc);
    logic [32:0] sum;
    sum = {1'b0, v} + 33'(inc);
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic [AGE_W-1:0] age_up(logic [AGE_W-1:0] a);
    return (a < AGE_MAX) ? a + AGE_W'(1) : a;
  endfunction

  // Configuration
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] block_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd4;
      ways_q       <= 4'd1;
      block_bits_q <= 6'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:    set_bits_q   <= cfg_data_i[2:0];
        CFG_WAYS_IN_USE: ways_q       <= cfg_data_i[3:0];
        CFG_BLOCK_BITS:  block_bits_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Address split
  logic [ADDR_WIDTH-1:0] addr_w, shifted, tag_d;
  logic [3:0]            s_eff;
  logic [6:0]            shift;
  logic [SET_W-1:0]      set_mask, set_d;

  always_comb begin
    addr_w   = in_i.address[ADDR_WIDTH-1:0];
    s_eff    = ({1'b0, set_bits_q} > SET_LIM_L) ? SET_LIM_L : {1'b0, set_bits_q};
    shift    = 7'(block_bits_q) + 7'(s_eff);
    set_mask = ~({SET_W{1'b1}} << s_eff);
    shifted  = addr_w >> block_bits_q;
    set_d    = shifted[SET_W-1:0] & set_mask;
    tag_d    = addr_w >> shift;
  end

  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [1:0]            type_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q  <= set_d;
      tag_q  <= tag_d;
      type_q <= in_i.req_type;
    end
  end

  assign sts_o.fetch = (type_q == REQ_IFETCH);

  // Set store: one row holds every way of a set
  logic [ROW_W-1:0]    rd_row, wr_row;
  logic [MAX_SETS-1:0] row_valid_q;

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write),
    .waddr_i(set_q),
    .wdata_i(wr_row),
    .re_i   (cmd_i.capture),
    .raddr_i(set_d),
    .rdata_o(rd_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (cmd_i.write) begin
      row_valid_q[set_q] <= 1'b1;
    end
  end

  // Effective way count
  logic [WCNT_W-1:0] nw;

  always_comb begin
    if (ways_q == 4'd0) begin
      nw = WCNT_W'(1);
    end else if (32'(ways_q) > 32'(MAX_WAYS)) begin
      nw = WCNT_W'(MAX_WAYS);
    end else begin
      nw = WCNT_W'(ways_q);
    end
  end

  // Unpack the row; a set never written reads as empty with zero ages
  logic                  vld [MAX_WAYS];
  logic [AGE_W-1:0]      age [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tg  [MAX_WAYS];

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld[w] = row_valid_q[set_q] & rd_row[w*ENT_W + ENT_W - 1];
      age[w] = row_valid_q[set_q] ? rd_row[w*ENT_W + ADDR_WIDTH +: AGE_W] : '0;
      tg[w]  = rd_row[w*ENT_W +: ADDR_WIDTH];
    end
  end

  // Lookup and replacement
  logic             found, empty_found;
  logic [WAY_W-1:0] fidx, eidx, vidx, repl;
  logic [AGE_W-1:0] max_age, old_age;

  always_comb begin
    found       = 1'b0;
    empty_found = 1'b0;
    fidx        = '0;
    eidx        = '0;
    // descend so that the lowest way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (WCNT_W'(w) < nw) begin
        if (vld[w] && tg[w] == tag_q) begin
          found = 1'b1;
          fidx  = WAY_W'(w);
        end
        if (!vld[w]) begin
          empty_found = 1'b1;
          eidx        = WAY_W'(w);
        end
      end
    end
    vidx    = '0;
    max_age = age[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (WCNT_W'(w) < nw && age[w] > max_age) begin
        max_age = age[w];
        vidx    = WAY_W'(w);
      end
    end
    repl    = empty_found ? eidx : vidx;
    old_age = age[fidx];
  end

  always_comb begin
    wr_row = rd_row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WCNT_W'(w) < nw) begin
        if (found) begin
          if (WAY_W'(w) == fidx) begin
            wr_row[w*ENT_W + ADDR_WIDTH +: AGE_W] = '0;
          end else if (age[w] < old_age) begin
            wr_row[w*ENT_W + ADDR_WIDTH +: AGE_W] = age_up(age[w]);
          end else begin
            wr_row[w*ENT_W + ADDR_WIDTH +: AGE_W] = age[w];
          end
          wr_row[w*ENT_W + ENT_W - 1] = vld[w];
        end else if (WAY_W'(w) == repl) begin
          wr_row[w*ENT_W +: ENT_W] = {1'b1, {AGE_W{1'b0}}, tag_q};
        end else begin
          wr_row[w*ENT_W + ADDR_WIDTH +: AGE_W] = age_up(age[w]);
          wr_row[w*ENT_W + ENT_W - 1]           = vld[w];
        end
      end else begin
        // keep out-of-use ways as stored
        wr_row[w*ENT_W + ADDR_WIDTH +: AGE_W] = age[w];
        wr_row[w*ENT_W + ENT_W - 1]           = vld[w];
      end
    end
  end

  // Totals and result
  logic        is_fetch, is_modify;
  logic        r_hit, r_miss, r_evict;
  logic [1:0]  hit_inc;
  logic [31:0] hits_q, misses_q, evicts_q;
  logic [31:0] hits_d, misses_d, evicts_d;
  salc_out_t   out_q;

  always_comb begin
    is_fetch  = (type_q == REQ_IFETCH);
    is_modify = (type_q == REQ_MODIFY);
    r_hit     = !is_fetch && found;
    r_miss    = !is_fetch && !found;
    r_evict   = r_miss && !empty_found;
    // a modify's second access always hits
    hit_inc   = 2'(r_hit) + 2'(is_modify);
    hits_d    = sat_add(hits_q, hit_inc);
    misses_d  = sat_add(misses_q, 2'(r_miss));
    evicts_d  = sat_add(evicts_q, 2'(r_evict));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.commit) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.hit            <= r_hit;
      out_q.miss           <= r_miss;
      out_q.eviction       <= r_evict;
      out_q.second_hit     <= is_modify;
      out_q.hit_total      <= hits_d;
      out_q.miss_total     <= misses_d;
      out_q.eviction_total <= evicts_d;
    end
  end

  assign out_o = out_q;

  `ASSERT_NEXT(a_row_marked, clk_i, rst_ni, cmd_i.write, row_valid_q[set_q])
  `ASSERT_NEXT(a_hits_grow, clk_i, rst_ni, cmd_i.commit, hits_q >= $past(hits_q))

endmodule

@@ rtl/set_assoc_lru_cache_model.sv @@
`timescale 1ns / 1ps

// Tag store of a set-associative cache with true LRU replacement. Each request
// (load, store, modify or ignored instruction fetch) has two steps: on accept
// the address is split and the whole set (all ways: valid, age, tag) is read
// from one RAM row; in lookup the ways are compared and, once the result
// register is free, ages and the replaced line are updated, the row is written
// back (not for a fetch) and the result is registered. A new request is taken
// only after lookup ends, set by that single read-then-write of the set row. A
// full result register lets the next request be accepted while the previous
// beat waits. Sets never written read as empty through per-set valid flops, so
// there is no clearing pass after reset. Configuration writes take effect at
// once; the user must make them only while the block is idle (not enforced).
module set_assoc_lru_cache_model import salc_pkg::*; #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  salc_in_t              in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output salc_out_t             out_o
);

  salc_cmd_t cmd;
  salc_sts_t sts;

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  salc_dp #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_o     (out_o)
  );

endmodule
